// ===== rtl/core/tsnfc_pkg.sv =====
// Shared types, constants and defaults for the TSN frame classifier.
`timescale 1ns / 1ps
`default_nettype none

package tsnfc_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int COUNTER_WIDTH_DEF = 32;
  localparam int OFFSET_WIDTH_DEF  = 16;

  // Depth of the class queue between the parser and the counters; a power of two.
  localparam int QUEUE_DEPTH = 4;

  // Field widths.
  localparam int BYTE_WIDTH       = 8;
  localparam int ETYPE_WIDTH      = 16;
  localparam int PCP_WIDTH        = 3;
  localparam int IHL_WIDTH        = 4;
  localparam int PROTO_WIDTH      = 8;
  localparam int PORT_WIDTH       = 16;
  localparam int RESULT_CNT_WIDTH = 32;
  localparam int CLASS_WIDTH      = 2;

  // Configuration port.
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = 16;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UDP_PORT  = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_VLAN_PRIO = 1'd1;
  localparam logic [PORT_WIDTH-1:0]      UDP_PORT_RST  = 16'd5000;
  localparam logic [PCP_WIDTH-1:0]       VLAN_PRIO_RST = 3'd3;

  // Frame layout.
  localparam int ETH_HDR_LEN    = 14;
  localparam int IPV4_MIN_WORDS = 5;
  localparam int WORD_BYTES     = 4;
  localparam int UDP_HDR_LEN    = 8;
  localparam int UDP_PORT_OFS   = 2;
  localparam int OFS_ETYPE_HI   = 12;
  localparam int OFS_ETYPE_LO   = 13;
  localparam int OFS_TAG        = 14;
  localparam int OFS_PROTO      = 23;

  localparam logic [ETYPE_WIDTH-1:0] ET_AVTP = 16'h22F0;
  localparam logic [ETYPE_WIDTH-1:0] ET_VLAN = 16'h8100;
  localparam logic [ETYPE_WIDTH-1:0] ET_QINQ = 16'h88A8;
  localparam logic [ETYPE_WIDTH-1:0] ET_IPV4 = 16'h0800;
  localparam logic [PROTO_WIDTH-1:0] PROTO_UDP = 8'd17;

  typedef enum logic [CLASS_WIDTH-1:0] {
    CLASS_TSN  = 2'd0,
    CLASS_BE   = 2'd1,
    CLASS_RUNT = 2'd2
  } frame_class_t;

  // Parser to queue.
  typedef struct packed {
    logic         push;
    frame_class_t cls;
  } cls_push_t;

  // Queue to counter unit.
  typedef struct packed {
    logic         valid;
    frame_class_t cls;
  } cls_head_t;

endpackage

`default_nettype wire

// ===== rtl/core/tsn_frame_classifier_counter.sv =====
// Top level of the TSN frame classifier and counter.
//
//   Channel   Direction  Signals                          Word
//   s_*       in         tvalid tready tdata[7:0] tlast   one frame byte, tlast on the final byte
//   m_*       out        tvalid tready tdata[95:0] tuser  frame class and the three counters
//   cfg_*     in         we index data[15:0]              register write, no read-back
//
// One byte is accepted every cycle while the class queue has room. A frame's
// result passes through the queue and then the output register. Reset is
// synchronous and clears the counters, the frame state and the registers to
// their defaults. A stalled output fills the four-entry class queue before
// s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module tsn_frame_classifier_counter
  import tsnfc_pkg::*;
#(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF,
  parameter int OFFSET_WIDTH  = OFFSET_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [BYTE_WIDTH-1:0]      s_tdata,   // frame_byte
  input  logic                       s_tlast,   // last_byte
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [3*RESULT_CNT_WIDTH-1:0] m_tdata, // total_frames, tsn_frames, best_effort_frames
  output logic [CLASS_WIDTH-1:0]     m_tuser,   // frame_class
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  logic [PORT_WIDTH-1:0]       tsn_port;
  logic [PCP_WIDTH-1:0]        tsn_vlan_priority;
  cls_push_t                   cls_push;
  cls_head_t                   head;
  logic                        queue_full;
  logic                        pop;
  frame_class_t                out_class;
  logic [RESULT_CNT_WIDTH-1:0] out_total;
  logic [RESULT_CNT_WIDTH-1:0] out_tsn;
  logic [RESULT_CNT_WIDTH-1:0] out_be;

  always_ff @(posedge clk) begin
    if (rst) begin
      tsn_port          <= UDP_PORT_RST;
      tsn_vlan_priority <= VLAN_PRIO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UDP_PORT:  tsn_port          <= cfg_data[PORT_WIDTH-1:0];
        CFG_VLAN_PRIO: tsn_vlan_priority <= cfg_data[PCP_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  tsnfc_parser #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (s_tvalid),
    .byte_data    (s_tdata),
    .byte_last    (s_tlast),
    .queue_full   (queue_full),
    .udp_port_cfg (tsn_port),
    .vlan_prio_cfg(tsn_vlan_priority),
    .byte_ready   (s_tready),
    .cls_push     (cls_push)
  );

  tsnfc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .cls_push(cls_push),
    .pop     (pop),
    .head    (head),
    .full    (queue_full)
  );

  tsnfc_counter #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_counter (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .out_ready(m_tready),
    .pop      (pop),
    .out_valid(m_tvalid),
    .out_class(out_class),
    .out_total(out_total),
    .out_tsn  (out_tsn),
    .out_be   (out_be)
  );

  assign m_tdata = {out_be, out_tsn, out_total};
  assign m_tuser = out_class;

  // A frame that has just ended is waiting in the queue on the next cycle.
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    cls_push.push |=> head.valid)
    else $error("class queue empty after a frame end");

  // Nothing leaves the queue while the output word is stalled.
  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !pop)
    else $error("queue popped while output stalled");

  // Input back-pressure only when the queue holds words.
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> head.valid)
    else $error("input stalled with an empty queue");

endmodule

`default_nettype wire

// ===== rtl/core/tsnfc_parser.sv =====
// Byte parser: captures header fields and classifies each frame on its last byte.
`timescale 1ns / 1ps
`default_nettype none

module tsnfc_parser
  import tsnfc_pkg::*;
#(
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  input  logic [BYTE_WIDTH-1:0] byte_data,
  input  logic                  byte_last,
  input  logic                  queue_full,
  input  logic [PORT_WIDTH-1:0] udp_port_cfg,
  input  logic [PCP_WIDTH-1:0]  vlan_prio_cfg,
  output logic                  byte_ready,
  output cls_push_t             cls_push
);

  localparam logic [OFFSET_WIDTH-1:0] OFS_MAX = {OFFSET_WIDTH{1'b1}};

  logic [OFFSET_WIDTH-1:0] byte_offset;
  logic [ETYPE_WIDTH-1:0]  ether_type;
  logic [PCP_WIDTH-1:0]    vlan_pcp;
  logic [IHL_WIDTH-1:0]    ip_header_words;
  logic [PROTO_WIDTH-1:0]  ip_protocol;
  logic [PORT_WIDTH-1:0]   udp_dest_port;

  logic [OFFSET_WIDTH-1:0] byte_offset_next;
  logic [ETYPE_WIDTH-1:0]  ether_type_next;
  logic [PCP_WIDTH-1:0]    vlan_pcp_next;
  logic [IHL_WIDTH-1:0]    ip_header_words_next;
  logic [PROTO_WIDTH-1:0]  ip_protocol_next;
  logic [PORT_WIDTH-1:0]   udp_dest_port_next;

  logic [OFFSET_WIDTH-1:0] udp_start;
  logic [OFFSET_WIDTH-1:0] udp_end;
  logic                    past_tag;
  logic                    accept;
  frame_class_t            cls;

  assign byte_ready = !queue_full;
  assign accept     = byte_valid && byte_ready;

  // The UDP header starts after the IPv4 header, whose length is taken from
  // the IHL captured before this byte.
  assign udp_start = OFFSET_WIDTH'(ETH_HDR_LEN)
                   + OFFSET_WIDTH'({ip_header_words, 2'b00});
  assign past_tag  = byte_offset > OFFSET_WIDTH'(ETH_HDR_LEN);

  always_comb begin
    ether_type_next      = ether_type;
    vlan_pcp_next        = vlan_pcp;
    ip_header_words_next = ip_header_words;
    ip_protocol_next     = ip_protocol;
    udp_dest_port_next   = udp_dest_port;

    if (byte_offset == OFFSET_WIDTH'(OFS_ETYPE_HI)) begin
      ether_type_next[15:8] = byte_data;
    end else if (byte_offset == OFFSET_WIDTH'(OFS_ETYPE_LO)) begin
      ether_type_next[7:0] = byte_data;
    end
    if (byte_offset == OFFSET_WIDTH'(OFS_TAG)) begin
      vlan_pcp_next        = byte_data[7:5];
      ip_header_words_next = byte_data[3:0];
    end
    if (byte_offset == OFFSET_WIDTH'(OFS_PROTO)) begin
      ip_protocol_next = byte_data;
    end
    if (past_tag && byte_offset == udp_start + OFFSET_WIDTH'(UDP_PORT_OFS)) begin
      udp_dest_port_next[15:8] = byte_data;
    end else if (past_tag &&
                 byte_offset == udp_start + OFFSET_WIDTH'(UDP_PORT_OFS + 1)) begin
      udp_dest_port_next[7:0] = byte_data;
    end

    byte_offset_next = (byte_offset == OFS_MAX) ? byte_offset
                                                : byte_offset + 1'b1;
  end

  // Frame length including this byte is byte_offset_next; a saturated count
  // lies beyond every threshold below.
  assign udp_end = OFFSET_WIDTH'(ETH_HDR_LEN + UDP_HDR_LEN)
                 + OFFSET_WIDTH'({ip_header_words_next, 2'b00});

  always_comb begin
    cls = CLASS_BE;
    if (byte_offset_next < OFFSET_WIDTH'(ETH_HDR_LEN)) begin
      cls = CLASS_RUNT;
    end else if (ether_type_next == ET_AVTP) begin
      cls = CLASS_TSN;
    end else if (ether_type_next == ET_VLAN || ether_type_next == ET_QINQ) begin
      if (byte_offset_next > OFFSET_WIDTH'(ETH_HDR_LEN) &&
          vlan_pcp_next == vlan_prio_cfg) begin
        cls = CLASS_TSN;
      end
    end else if (ether_type_next == ET_IPV4) begin
      if (byte_offset_next >= OFFSET_WIDTH'(ETH_HDR_LEN + WORD_BYTES * IPV4_MIN_WORDS) &&
          ip_header_words_next >= IHL_WIDTH'(IPV4_MIN_WORDS) &&
          ip_protocol_next == PROTO_UDP &&
          byte_offset_next >= udp_end &&
          udp_dest_port_next == udp_port_cfg) begin
        cls = CLASS_TSN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset     <= '0;
      ether_type      <= '0;
      vlan_pcp        <= '0;
      ip_header_words <= '0;
      ip_protocol     <= '0;
      udp_dest_port   <= '0;
    end else if (accept) begin
      if (byte_last) begin
        byte_offset     <= '0;
        ether_type      <= '0;
        vlan_pcp        <= '0;
        ip_header_words <= '0;
        ip_protocol     <= '0;
        udp_dest_port   <= '0;
      end else begin
        byte_offset     <= byte_offset_next;
        ether_type      <= ether_type_next;
        vlan_pcp        <= vlan_pcp_next;
        ip_header_words <= ip_header_words_next;
        ip_protocol     <= ip_protocol_next;
        udp_dest_port   <= udp_dest_port_next;
      end
    end
  end

  assign cls_push.push = accept && byte_last;
  assign cls_push.cls  = cls;

endmodule

`default_nettype wire

// ===== rtl/core/tsnfc_queue.sv =====
// Short class queue between the parser and the counter unit.
`timescale 1ns / 1ps
`default_nettype none

module tsnfc_queue
  import tsnfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cls_push_t cls_push,
  input  logic      pop,
  output cls_head_t head,
  output logic      full
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  frame_class_t entries [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   fill;
  logic          do_pop;

  assign full       = fill == (AW + 1)'(QUEUE_DEPTH);
  assign head.valid = fill != '0;
  assign head.cls   = entries[rd_ptr];
  assign do_pop     = pop && head.valid;

  // Pointers wrap on their own since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (cls_push.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (cls_push.push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (!cls_push.push && do_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cls_push.push) begin
      entries[wr_ptr] <= cls_push.cls;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tsnfc_counter.sv =====
// Counter unit: bumps the frame counters and holds the result word for the output.
`timescale 1ns / 1ps
`default_nettype none

module tsnfc_counter
  import tsnfc_pkg::*;
#(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cls_head_t                   head,
  input  logic                        out_ready,
  output logic                        pop,
  output logic                        out_valid,
  output frame_class_t                out_class,
  output logic [RESULT_CNT_WIDTH-1:0] out_total,
  output logic [RESULT_CNT_WIDTH-1:0] out_tsn,
  output logic [RESULT_CNT_WIDTH-1:0] out_be
);

  logic [COUNTER_WIDTH-1:0] total_count;
  logic [COUNTER_WIDTH-1:0] tsn_count;
  logic [COUNTER_WIDTH-1:0] best_effort_count;
  logic [COUNTER_WIDTH-1:0] total_count_next;
  logic [COUNTER_WIDTH-1:0] tsn_count_next;
  logic [COUNTER_WIDTH-1:0] best_effort_count_next;

  // The output register takes a new word when it is empty or being emptied.
  assign pop = head.valid && (!out_valid || out_ready);

  always_comb begin
    total_count_next       = total_count;
    tsn_count_next         = tsn_count;
    best_effort_count_next = best_effort_count;
    case (head.cls)
      CLASS_TSN: begin
        total_count_next = total_count + 1'b1;
        tsn_count_next   = tsn_count + 1'b1;
      end
      CLASS_BE: begin
        total_count_next       = total_count + 1'b1;
        best_effort_count_next = best_effort_count + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      total_count       <= '0;
      tsn_count         <= '0;
      best_effort_count <= '0;
    end else if (pop) begin
      out_valid         <= 1'b1;
      total_count       <= total_count_next;
      tsn_count         <= tsn_count_next;
      best_effort_count <= best_effort_count_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_class <= head.cls;
      out_total <= RESULT_CNT_WIDTH'(total_count_next);
      out_tsn   <= RESULT_CNT_WIDTH'(tsn_count_next);
      out_be    <= RESULT_CNT_WIDTH'(best_effort_count_next);
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tsn_frame_classifier_counter_checker.sv =====
// Checker for the TSN frame classifier: predicts each frame's result and compares it.
`timescale 1ns / 1ps

module tsn_frame_classifier_counter_checker
  import tsnfc_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [BYTE_WIDTH-1:0]         s_tdata,   // frame_byte
  input  logic                          s_tlast,   // last_byte
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [3*RESULT_CNT_WIDTH-1:0] m_tdata,   // total_frames, tsn_frames, best_effort_frames
  input  logic [CLASS_WIDTH-1:0]        m_tuser,   // frame_class
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]     cfg_data,
  output int                            fail_count,
  output int                            pending_count
);

  typedef struct packed {
    frame_class_t                cls;
    logic [RESULT_CNT_WIDTH-1:0] total;
    logic [RESULT_CNT_WIDTH-1:0] tsn;
    logic [RESULT_CNT_WIDTH-1:0] be;
  } frame_tally_t;

  frame_tally_t tally_q[$];
  frame_tally_t head;

  logic [PORT_WIDTH-1:0]       port_reg;
  logic [PCP_WIDTH-1:0]        pcp_reg;
  logic [OFFSET_WIDTH_DEF-1:0] bytes_seen;
  logic [ETYPE_WIDTH-1:0]      etype_cap;
  logic [PCP_WIDTH-1:0]        pcp_cap;
  logic [IHL_WIDTH-1:0]        ihl_cap;
  logic [PROTO_WIDTH-1:0]      proto_cap;
  logic [PORT_WIDTH-1:0]       dport_cap;
  logic [RESULT_CNT_WIDTH-1:0] total_cnt;
  logic [RESULT_CNT_WIDTH-1:0] tsn_cnt;
  logic [RESULT_CNT_WIDTH-1:0] be_cnt;
  int                          fails = 0;

  task automatic clear_frame;
    bytes_seen = '0;
    etype_cap  = '0;
    pcp_cap    = '0;
    ihl_cap    = '0;
    proto_cap  = '0;
    dport_cap  = '0;
  endtask

  function automatic frame_class_t class_of(input int len);
    int udp_end;
    udp_end = ETH_HDR_LEN + WORD_BYTES * int'(ihl_cap) + UDP_HDR_LEN;
    if (etype_cap == ET_AVTP)
      return CLASS_TSN;
    if (etype_cap == ET_VLAN || etype_cap == ET_QINQ)
      return (len > ETH_HDR_LEN && pcp_cap == pcp_reg) ? CLASS_TSN : CLASS_BE;
    // An IPv4 frame needs a whole IP header and a whole UDP header to qualify.
    if (etype_cap == ET_IPV4 && len >= ETH_HDR_LEN + WORD_BYTES * IPV4_MIN_WORDS &&
        ihl_cap >= IPV4_MIN_WORDS && proto_cap == PROTO_UDP && len >= udp_end &&
        dport_cap == port_reg)
      return CLASS_TSN;
    return CLASS_BE;
  endfunction

  task automatic take_byte(input logic [BYTE_WIDTH-1:0] b, input logic l);
    int           off;
    int           udp_start;
    int           len;
    frame_tally_t t;
    off       = int'(bytes_seen);
    // The UDP offset uses the header length captured on an earlier byte.
    udp_start = ETH_HDR_LEN + WORD_BYTES * int'(ihl_cap);
    if (off == OFS_ETYPE_HI)
      etype_cap[15:8] = b;
    else if (off == OFS_ETYPE_LO)
      etype_cap[7:0] = b;
    if (off == OFS_TAG) begin
      pcp_cap = b[7:5];
      ihl_cap = b[3:0];
    end
    if (off == OFS_PROTO)
      proto_cap = b;
    if (off > ETH_HDR_LEN && off == udp_start + UDP_PORT_OFS)
      dport_cap[15:8] = b;
    else if (off > ETH_HDR_LEN && off == udp_start + UDP_PORT_OFS + 1)
      dport_cap[7:0] = b;
    if (bytes_seen != '1)
      bytes_seen = bytes_seen + 1'b1;
    if (l) begin
      len = int'(bytes_seen);
      if (len < ETH_HDR_LEN) begin
        t.cls = CLASS_RUNT;
      end else begin
        t.cls     = class_of(len);
        total_cnt = total_cnt + 1'b1;
        if (t.cls == CLASS_TSN)
          tsn_cnt = tsn_cnt + 1'b1;
        else
          be_cnt = be_cnt + 1'b1;
      end
      t.total = total_cnt;
      t.tsn   = tsn_cnt;
      t.be    = be_cnt;
      tally_q.push_back(t);
      clear_frame();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      port_reg  = UDP_PORT_RST;
      pcp_reg   = VLAN_PRIO_RST;
      total_cnt = '0;
      tsn_cnt   = '0;
      be_cnt    = '0;
      clear_frame();
      tally_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_UDP_PORT)
          port_reg = cfg_data[PORT_WIDTH-1:0];
        else if (cfg_index == CFG_VLAN_PRIO)
          pcp_reg = cfg_data[PCP_WIDTH-1:0];
      end
      if (m_tvalid && m_tready) begin
        if (tally_q.size() == 0) begin
          $display("%0t: result word with no frame pending, expected none, actual class %0d",
                   $time, m_tuser);
          fails++;
        end else begin
          head = tally_q.pop_front();
          check_field("frame_class", 32'(head.cls), 32'(m_tuser));
          check_field("total_frames", head.total, m_tdata[31:0]);
          check_field("tsn_frames", head.tsn, m_tdata[63:32]);
          check_field("best_effort_frames", head.be, m_tdata[95:64]);
        end
      end
      if (s_tvalid && s_tready)
        take_byte(s_tdata, s_tlast);
    end
    fail_count    <= fails;
    pending_count <= tally_q.size();
  end

endmodule

// ===== tb/sv/tsn_frame_classifier_counter_tb.sv =====
// Testbench top for the TSN frame classifier: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps

module tsn_frame_classifier_counter_tb;
  import tsnfc_pkg::*;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          s_tvalid  = 1'b0;
  logic                          s_tready;
  logic [BYTE_WIDTH-1:0]         s_tdata   = '0;
  logic                          s_tlast   = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready  = 1'b0;
  logic [3*RESULT_CNT_WIDTH-1:0] m_tdata;
  logic [CLASS_WIDTH-1:0]        m_tuser;
  logic                          cfg_we    = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0]    cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]     cfg_data  = '0;
  int                            fail_count;
  int                            pending_count;

  int                    send_idle_pct  = 0;
  int                    recv_stall_pct = 0;
  logic [PORT_WIDTH-1:0] cur_port       = UDP_PORT_RST;
  logic [PCP_WIDTH-1:0]  cur_pcp        = VLAN_PRIO_RST;
  logic [7:0]            frame_buf[$];
  int                    phase_bytes;
  int                    phase_frames;

  tsn_frame_classifier_counter i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tsn_frame_classifier_counter_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Random bytes with the header fields laid over them, cut to the frame length.
  task automatic build_frame(input int len, input logic [15:0] etype, input logic [7:0] tag,
                             input logic [7:0] proto, input logic [15:0] port);
    int dport_at;
    int fill;
    dport_at = ETH_HDR_LEN + WORD_BYTES * int'(tag[3:0]) + UDP_PORT_OFS;
    fill     = (len > dport_at + 2) ? len : dport_at + 2;
    frame_buf.delete();
    for (int i = 0; i < fill; i++)
      frame_buf.push_back(8'($urandom_range(0, 255)));
    frame_buf[OFS_ETYPE_HI] = etype[15:8];
    frame_buf[OFS_ETYPE_LO] = etype[7:0];
    frame_buf[OFS_TAG]      = tag;
    frame_buf[OFS_PROTO]    = proto;
    frame_buf[dport_at]     = port[15:8];
    frame_buf[dport_at + 1] = port[7:0];
    while (frame_buf.size() > len)
      void'(frame_buf.pop_back());
  endtask

  task automatic send_word(input logic [7:0] b, input logic l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_frame;
    for (int i = 0; i < frame_buf.size(); i++)
      send_word(frame_buf[i], i == frame_buf.size() - 1);
    phase_bytes  += frame_buf.size();
    phase_frames++;
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic directed_frame(input int len, input logic [15:0] etype, input logic [7:0] tag,
                                input logic [7:0] proto, input logic [15:0] port);
    build_frame(len, etype, tag, proto, port);
    send_frame();
  endtask

  task automatic run_phase(input logic [15:0] port_v, input logic [2:0] pcp_v,
                           input int idle_pct, input int stall_pct);
    logic [12:0] junk;
    logic [15:0] et;
    logic [15:0] port;
    logic [7:0]  tag_rnd;
    logic [7:0]  proto;
    logic [2:0]  pcp;
    int          ihl;
    int          udp_end;
    int          len;
    drain();
    // The block is left to settle before the registers are rewritten.
    repeat (4) @(posedge clk);
    junk      = 13'($urandom_range(0, 8191));
    cfg_we    <= 1'b1;
    cfg_index <= CFG_UDP_PORT;
    cfg_data  <= port_v;
    @(posedge clk);
    cfg_index <= CFG_VLAN_PRIO;
    cfg_data  <= {junk, pcp_v};
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_port       = port_v;
    cur_pcp        = pcp_v;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    phase_bytes    = 0;
    phase_frames   = 0;
    while (phase_bytes < 45 || phase_frames < 3) begin
      tag_rnd = 8'($urandom_range(0, 255));
      ihl     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : IPV4_MIN_WORDS;
      pcp     = $urandom_range(0, 1) ? cur_pcp : 3'($urandom_range(0, 7));
      port    = ($urandom_range(0, 2) != 0) ? cur_port : 16'($urandom_range(0, 65535));
      proto   = ($urandom_range(0, 4) != 0) ? PROTO_UDP : 8'($urandom_range(0, 255));
      udp_end = ETH_HDR_LEN + WORD_BYTES * ihl + UDP_HDR_LEN;
      case ($urandom_range(0, 9))
        0: build_frame($urandom_range(1, 13), ET_IPV4, 8'h45, PROTO_UDP, port);
        1: build_frame($urandom_range(14, 30), ET_AVTP, tag_rnd, proto, port);
        2: begin
          et = $urandom_range(0, 1) ? ET_VLAN : ET_QINQ;
          build_frame($urandom_range(14, 24), et, {pcp, tag_rnd[4:0]}, proto, port);
        end
        3, 4, 5: begin
          case ($urandom_range(0, 3))
            0:       len = udp_end + $urandom_range(0, 3);
            1:       len = udp_end - 1;
            2:       len = $urandom_range(14, 34);
            default: len = $urandom_range(14, udp_end + 4);
          endcase
          build_frame(len, ET_IPV4, {tag_rnd[7:4], ihl[3:0]}, proto, port);
        end
        6: begin
          case ($urandom_range(0, 3))
            0:       et = ET_VLAN;
            1:       et = ET_QINQ;
            2:       et = ET_AVTP;
            default: et = ET_IPV4;
          endcase
          build_frame(ETH_HDR_LEN, et, tag_rnd, proto, port);
        end
        7: build_frame($urandom_range(14, 40), 16'($urandom_range(0, 65535)), tag_rnd, proto,
                       port);
        default: build_frame($urandom_range(1, 40), 16'($urandom_range(0, 65535)), tag_rnd,
                             8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
      endcase
      send_frame();
      // Now and then the source holds off until the block has emptied.
      if ($urandom_range(0, 15) == 0)
        drain();
    end
  endtask

  initial begin
    int wait_cycles;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Hand-picked frames against the register defaults, no idling on either side.
    directed_frame(1, ET_IPV4, 8'h45, PROTO_UDP, cur_port);
    directed_frame(13, ET_AVTP, 8'h45, PROTO_UDP, cur_port);
    directed_frame(14, 16'h0000, 8'h00, 8'h00, 16'h0000);
    directed_frame(14, ET_VLAN, 8'h60, PROTO_UDP, cur_port);
    directed_frame(15, ET_VLAN, 8'h7F, PROTO_UDP, cur_port);
    directed_frame(18, ET_VLAN, 8'h40, PROTO_UDP, cur_port);
    directed_frame(14, ET_AVTP, 8'hFF, 8'hFF, 16'hFFFF);
    directed_frame(33, ET_IPV4, 8'h45, PROTO_UDP, cur_port);
    directed_frame(42, ET_IPV4, 8'h45, PROTO_UDP, cur_port);
    directed_frame(41, ET_IPV4, 8'h45, PROTO_UDP, cur_port);
    directed_frame(46, ET_IPV4, 8'h46, PROTO_UDP, cur_port);
    directed_frame(45, ET_IPV4, 8'h46, PROTO_UDP, cur_port);

    run_phase(16'h0000, 3'd0, 0, 0);
    run_phase(16'hFFFF, 3'd7, 61, 0);
    run_phase(16'($urandom_range(0, 65535)), 3'($urandom_range(0, 7)), 0, 61);
    run_phase(16'($urandom_range(0, 65535)), 3'($urandom_range(0, 7)), 29, 29);
    run_phase(16'($urandom_range(0, 65535)), 3'd0, 29, 29);

    s_tvalid    <= 1'b0;
    wait_cycles = 0;
    do begin
      @(posedge clk);
      wait_cycles++;
    end while (pending_count != 0 && wait_cycles < 20000);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tsnfc_pkg.sv
rtl/core/tsnfc_parser.sv
rtl/core/tsnfc_queue.sv
rtl/core/tsnfc_counter.sv
rtl/core/tsn_frame_classifier_counter.sv
tb/sv/tsn_frame_classifier_counter_checker.sv
tb/sv/tsn_frame_classifier_counter_tb.sv
